FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file ifr_checker.sv. All run on clk_i and are
// off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and line constants of the I-frame receiver.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] CTRL_I0   = 8'h00;
  localparam logic [7:0] CTRL_I1   = 8'h80;

  // Receiver phase; the spare code behaves as hunting.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_TOO_LONG  = 4'd2,
    ST_TOO_SHORT = 4'd3,
    ST_BCC1      = 4'd4,
    ST_NOT_I     = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_ESCAPE    = 4'd7,
    ST_OVERFLOW  = 4'd8,
    ST_BCC2      = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_RR   = 2'd1,
    RPL_REJ  = 2'd2
  } reply_e;

  // Result item fields of fixed width (length travels beside it).
  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    status_e    status;
    reply_e     reply_kind;
    logic       reply_bit;
    logic       frame_seq;
  } res_t;

endpackage

FILE: rtl/ifr_core.sv
// ----------------------------------------------------------------------------
// ifr_core
// Frame state and per-byte update: flag hunt, header latch, unstuffing,
// running XOR and end-of-frame verdict.
// ----------------------------------------------------------------------------
module ifr_core #(
  parameter int MAX_PAYLOAD = 256,
  parameter int MAX_FRAME   = 528,
  localparam int LenW       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [7:0]         byte_i,
  output logic               res_valid_o,
  output ifr_pkg::res_t      res_o,
  output logic [LenW-1:0]    res_len_o
);

  localparam int RawW  = $clog2(MAX_FRAME + 1);
  localparam int BodyW = $clog2(MAX_PAYLOAD + 2);

  ifr_pkg::phase_e  phase_q, phase_d;
  logic [RawW-1:0]  raw_q, raw_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [7:0]       hchk_q, hchk_d;
  logic             esc_q, esc_d;
  logic [7:0]       held_q, held_d;
  logic [BodyW-1:0] body_q, body_d;
  logic [7:0]       xor_q, xor_d;
  logic             ovf_q, ovf_d;
  logic             exp_q, exp_d;

  logic             in_frame, is_flag, skip_flag, too_long, long_hit, closing;
  logic             body_byte, push, push_room, emit_data;
  logic [RawW-1:0]  raw_inc;
  logic [7:0]       val;
  logic             seq;

  ifr_pkg::status_e v_st;
  ifr_pkg::reply_e  v_kind;
  logic             v_bit, v_seq;
  logic [LenW-1:0]  v_len;

  // Byte decode
  assign in_frame  = (phase_q == ifr_pkg::PH_HDR) || (phase_q == ifr_pkg::PH_BODY);
  assign is_flag   = (byte_i == ifr_pkg::FLAG_BYTE);
  assign skip_flag = (phase_q == ifr_pkg::PH_HDR) && (raw_q == RawW'(1)) && is_flag;
  assign too_long  = (raw_q >= RawW'(MAX_FRAME));
  assign long_hit  = in_frame && !skip_flag && too_long;
  assign raw_inc   = raw_q + RawW'(1);
  assign closing   = in_frame && !skip_flag && !too_long && is_flag;
  assign body_byte = (phase_q == ifr_pkg::PH_BODY) && !too_long && !is_flag;
  assign push      = body_byte && (esc_q || (byte_i != ifr_pkg::ESC_BYTE));
  assign val       = esc_q ? (byte_i ^ ifr_pkg::ESC_MASK) : byte_i;
  assign push_room = (body_q < BodyW'(MAX_PAYLOAD + 1));
  assign emit_data = push && !ovf_q && push_room && (body_q != '0);
  assign seq       = (ctrl_q == ifr_pkg::CTRL_I1);

  // End-of-frame verdict, in check order
  always_comb begin
    v_st   = ifr_pkg::ST_ACCEPTED;
    v_kind = ifr_pkg::RPL_NONE;
    v_bit  = 1'b0;
    v_seq  = seq;
    v_len  = '0;
    if (raw_inc < RawW'(5)) begin
      v_st  = ifr_pkg::ST_TOO_SHORT;
      v_seq = 1'b0;
    end else if (hchk_q != (addr_q ^ ctrl_q)) begin
      v_st = ifr_pkg::ST_BCC1;
    end else if ((ctrl_q != ifr_pkg::CTRL_I0) && (ctrl_q != ifr_pkg::CTRL_I1)) begin
      v_st = ifr_pkg::ST_NOT_I;
    end else if ((raw_inc == RawW'(5)) || ovf_q || esc_q || (body_q == '0) ||
                 (xor_q != 8'h00)) begin
      v_kind = ifr_pkg::RPL_REJ;
      v_bit  = exp_q;
      if (raw_inc == RawW'(5))  v_st = ifr_pkg::ST_EMPTY;
      else if (ovf_q)           v_st = ifr_pkg::ST_OVERFLOW;
      else if (esc_q)           v_st = ifr_pkg::ST_ESCAPE;
      else if (body_q == '0)    v_st = ifr_pkg::ST_EMPTY;
      else                      v_st = ifr_pkg::ST_BCC2;
    end else if (seq == exp_q) begin
      v_st   = ifr_pkg::ST_ACCEPTED;
      v_kind = ifr_pkg::RPL_RR;
      v_bit  = ~exp_q;
      v_len  = LenW'(body_q - BodyW'(1));
    end else begin
      v_st   = ifr_pkg::ST_DUPLICATE;
      v_kind = ifr_pkg::RPL_RR;
      v_bit  = exp_q;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    raw_d   = raw_q;
    addr_d  = addr_q;
    ctrl_d  = ctrl_q;
    hchk_d  = hchk_q;
    esc_d   = esc_q;
    held_d  = held_q;
    body_d  = body_q;
    xor_d   = xor_q;
    ovf_d   = ovf_q;
    exp_d   = exp_q;
    if (acc_i) begin
      case (phase_q)
        ifr_pkg::PH_HDR, ifr_pkg::PH_BODY: begin
          if (!skip_flag) begin
            if (too_long) begin
              phase_d = ifr_pkg::PH_HUNT;
            end else begin
              raw_d = raw_inc;
              if (is_flag) begin
                phase_d = ifr_pkg::PH_HUNT;
                if ((v_st == ifr_pkg::ST_ACCEPTED) && (v_kind == ifr_pkg::RPL_RR)) begin
                  exp_d = ~exp_q;
                end
              end else if (phase_q == ifr_pkg::PH_HDR) begin
                if (raw_inc == RawW'(2)) begin
                  addr_d = byte_i;
                end else if (raw_inc == RawW'(3)) begin
                  ctrl_d = byte_i;
                end else begin
                  hchk_d  = byte_i;
                  phase_d = ifr_pkg::PH_BODY;
                end
              end else begin
                if (esc_q) esc_d = 1'b0;
                else if (byte_i == ifr_pkg::ESC_BYTE) esc_d = 1'b1;
                if (push && !ovf_q) begin
                  if (!push_room) begin
                    ovf_d = 1'b1;
                  end else begin
                    held_d = val;
                    body_d = body_q + BodyW'(1);
                    xor_d  = xor_q ^ val;
                  end
                end
              end
            end
          end
        end
        default: begin
          if (is_flag) begin
            phase_d = ifr_pkg::PH_HDR;
            raw_d   = RawW'(1);
            addr_d  = '0;
            ctrl_d  = '0;
            hchk_d  = '0;
            esc_d   = 1'b0;
            held_d  = '0;
            body_d  = '0;
            xor_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    res_valid_o = acc_i && (long_hit || closing || emit_data);
    res_o       = '0;
    res_len_o   = '0;
    if (long_hit) begin
      res_o.is_status = 1'b1;
      res_o.status    = ifr_pkg::ST_TOO_LONG;
    end else if (closing) begin
      res_o.is_status  = 1'b1;
      res_o.status     = v_st;
      res_o.reply_kind = v_kind;
      res_o.reply_bit  = v_bit;
      res_o.frame_seq  = v_seq;
      res_len_o        = v_len;
    end else if (emit_data) begin
      res_o.data_byte = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ifr_pkg::PH_HUNT;
      raw_q   <= '0;
      addr_q  <= '0;
      ctrl_q  <= '0;
      hchk_q  <= '0;
      esc_q   <= 1'b0;
      held_q  <= '0;
      body_q  <= '0;
      xor_q   <= '0;
      ovf_q   <= 1'b0;
      exp_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      raw_q   <= raw_d;
      addr_q  <= addr_d;
      ctrl_q  <= ctrl_d;
      hchk_q  <= hchk_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
      body_q  <= body_d;
      xor_q   <= xor_d;
      ovf_q   <= ovf_d;
      exp_q   <= exp_d;
    end
  end

endmodule

FILE: rtl/ifr_outbuf.sv
// ----------------------------------------------------------------------------
// ifr_outbuf
// Result register with one skid entry; upstream stall is registered.
// ----------------------------------------------------------------------------
module ifr_outbuf #(
  parameter int Width = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [Width-1:0] out_q, out_d;
  logic [Width-1:0] skid_q, skid_d;
  logic             take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/info_frame_receiver.sv
// ----------------------------------------------------------------------------
// info_frame_receiver
// Byte-stuffed I-frame receiver with stop-and-wait sequencing.
// ----------------------------------------------------------------------------
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------
//   in      | in_valid_i  | in_stall_o  | rx_byte_i
//   out     | out_valid_o | out_stall_i | is_status_o, data_byte_o, status_o,
//           |             |             | payload_length_o, reply_kind_o,
//           |             |             | reply_bit_o, frame_seq_o
//
// One line byte is taken per cycle while in_stall_o is low; the frame state
// updates at that edge and any result is registered (output register, or
// skid entry while held). in_stall_o is the registered skid-full flag, so
// a stalled consumer holds off the line after two results back up.
// Reset (async, active low) clears the frame state, the expected sequence
// bit and both output entries; the block hunts for a flag afterwards.
//
// Data items trail the line by one body byte; the trailing BCC2 never
// leaves. The status item closes every frame.
// ----------------------------------------------------------------------------
module info_frame_receiver #(
  parameter int MAX_PAYLOAD = 256,
  parameter int MAX_FRAME   = 528,
  localparam int LenW       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // line side
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  // result side
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            is_status_o,
  output logic [7:0]      data_byte_o,
  output logic [3:0]      status_o,
  output logic [LenW-1:0] payload_length_o,
  output logic [1:0]      reply_kind_o,
  output logic            reply_bit_o,
  output logic            frame_seq_o
);

  localparam int ResW = LenW + 17;

  logic            acc;
  logic            res_valid;
  ifr_pkg::res_t   res;
  logic [LenW-1:0] res_len;
  logic [ResW-1:0] res_vec, out_vec;
  logic            ob_full;

  // item taken only while the skid entry is free
  assign in_stall_o = ob_full;
  assign acc        = in_valid_i && !ob_full;

  ifr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_FRAME   (MAX_FRAME)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_len_o   (res_len)
  );

  // flat layout: is_status | data | status | length | kind | bit | seq
  assign res_vec = {res.is_status, res.data_byte, res.status, res_len,
                    res.reply_kind, res.reply_bit, res.frame_seq};

  ifr_outbuf #(
    .Width (ResW)
  ) u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_vec),
    .full_o      (ob_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_vec)
  );

  assign frame_seq_o      = out_vec[0];
  assign reply_bit_o      = out_vec[1];
  assign reply_kind_o     = out_vec[3:2];
  assign payload_length_o = out_vec[LenW+3:4];
  assign status_o         = out_vec[LenW+7:LenW+4];
  assign data_byte_o      = out_vec[LenW+15:LenW+8];
  assign is_status_o      = out_vec[LenW+16];

endmodule

FILE: rtl/ifr_checker.sv
// ----------------------------------------------------------------------------
// ifr_checker
// Port-level checks on the receiver's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifr_checker #(
  parameter int MAX_PAYLOAD = 256,
  localparam int LenW       = $clog2(MAX_PAYLOAD + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            is_status_o,
  input logic [7:0]      data_byte_o,
  input logic [3:0]      status_o,
  input logic [LenW-1:0] payload_length_o,
  input logic [1:0]      reply_kind_o
);

  // held result stays put
  `ASSERT_NEXT(a_hold, out_valid_o && out_stall_i,
               out_valid_o && $stable(is_status_o) && $stable(data_byte_o) &&
               $stable(status_o))

  // data items carry no verdict and no reply
  `ASSERT_IMPLIES(a_data_clean, out_valid_o && !is_status_o,
                  (status_o == ifr_pkg::ST_ACCEPTED) && (reply_kind_o == ifr_pkg::RPL_NONE))

  // accepted and duplicate frames are acknowledged with RR
  `ASSERT_IMPLIES(a_rr, out_valid_o && is_status_o &&
                  ((status_o == ifr_pkg::ST_ACCEPTED) || (status_o == ifr_pkg::ST_DUPLICATE)),
                  reply_kind_o == ifr_pkg::RPL_RR)

  // body errors are rejected
  `ASSERT_IMPLIES(a_rej, out_valid_o && is_status_o &&
                  ((status_o == ifr_pkg::ST_EMPTY) || (status_o == ifr_pkg::ST_ESCAPE) ||
                   (status_o == ifr_pkg::ST_OVERFLOW) || (status_o == ifr_pkg::ST_BCC2)),
                  reply_kind_o == ifr_pkg::RPL_REJ)

  // a length is reported only for an accepted frame
  `ASSERT_IMPLIES(a_len, out_valid_o && (payload_length_o != '0),
                  is_status_o && (status_o == ifr_pkg::ST_ACCEPTED))

endmodule

bind info_frame_receiver ifr_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_ifr_checker (.*);

FILE: sim/tb_info_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_info_frame_receiver
// Self-checking bench for the I-frame receiver. A queue of line bytes feeds a
// clocked driver; every accepted item runs through a local predictor of the
// unstuffing, BCC and sequence logic, and a clocked monitor compares each
// result item field by field against the oldest prediction. Both sides idle
// at random, with one quiet stretch, one long result hold-off and two pauses
// until the block has drained.
// ----------------------------------------------------------------------------
module tb_info_frame_receiver;

  localparam int MaxPayload  = 256;
  localparam int MaxFrame    = 528;
  localparam int TargetBytes = 1250;
  localparam int CycleLimit  = 200000;
  // window with no idling on either side
  localparam int CalmFrom    = 600;
  localparam int CalmTo      = 1400;
  // long result hold-off, started once enough line bytes have gone in
  localparam int HoldoffAt   = 700;
  localparam int HoldoffLen  = 120;
  localparam int TailCycles  = 10;

  // One result item as the block presents it.
  typedef struct packed {
    logic             is_st;
    logic [7:0]       data;
    ifr_pkg::status_e st;
    logic [8:0]       len;
    ifr_pkg::reply_e  reply;
    logic             rbit;
    logic             fseq;
  } rx_result_t;

  // One line byte; wait_drained holds it back until no result is due.
  typedef struct {
    logic [7:0] value;
    bit         wait_drained;
  } line_byte_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       is_status_o;
  logic [7:0] data_byte_o;
  logic [3:0] status_o;
  logic [8:0] payload_length_o;
  logic [1:0] reply_kind_o;
  logic       reply_bit_o;
  logic       frame_seq_o;

  line_byte_t line_q[$];
  rx_result_t due_q[$];

  int unsigned cycle_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned payload_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned verdict_cnt[16];
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  // Predictor state, as after reset.
  ifr_pkg::phase_e ph       = ifr_pkg::PH_HUNT;
  int unsigned     raw_cnt  = 0;
  int unsigned     body_cnt = 0;
  logic [7:0]      addr_q   = 8'h00;
  logic [7:0]      ctrl_q   = 8'h00;
  logic [7:0]      bcc1_q   = 8'h00;
  logic [7:0]      held_q   = 8'h00;
  logic [7:0]      xor_q    = 8'h00;
  logic            esc_q    = 1'b0;
  logic            ovf_q    = 1'b0;
  logic            exp_seq  = 1'b0;

  info_frame_receiver #(
    .MAX_PAYLOAD(MaxPayload),
    .MAX_FRAME  (MaxFrame)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_status_o     (is_status_o),
    .data_byte_o     (data_byte_o),
    .status_o        (status_o),
    .payload_length_o(payload_length_o),
    .reply_kind_o    (reply_kind_o),
    .reply_bit_o     (reply_bit_o),
    .frame_seq_o     (frame_seq_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void post_verdict(input ifr_pkg::status_e st,
                                       input logic [8:0] len,
                                       input ifr_pkg::reply_e rk, input logic rb,
                                       input logic fs);
    rx_result_t r;
    r       = '0;
    r.is_st = 1'b1;
    r.st    = st;
    r.len   = len;
    r.reply = rk;
    r.rbit  = rb;
    r.fseq  = fs;
    due_q.push_back(r);
  endfunction

  // Advances the frame state by one line byte and queues what it yields.
  function automatic void rx_line_step(input logic [7:0] b);
    rx_result_t       r;
    logic [7:0]       v;
    logic             seq;
    ifr_pkg::status_e st;
    // hunting (and the spare phase code): only a flag matters
    if (ph != ifr_pkg::PH_HDR && ph != ifr_pkg::PH_BODY) begin
      if (b == ifr_pkg::FLAG_BYTE) begin
        ph       = ifr_pkg::PH_HDR;
        raw_cnt  = 1;
        body_cnt = 0;
        addr_q   = 8'h00;
        ctrl_q   = 8'h00;
        bcc1_q   = 8'h00;
        held_q   = 8'h00;
        xor_q    = 8'h00;
        esc_q    = 1'b0;
        ovf_q    = 1'b0;
      end
      return;
    end
    // repeated opening flags are swallowed
    if (ph == ifr_pkg::PH_HDR && raw_cnt == 1 && b == ifr_pkg::FLAG_BYTE) return;
    // frame already at its length cap: this byte ends it
    if (raw_cnt >= MaxFrame) begin
      ph = ifr_pkg::PH_HUNT;
      post_verdict(ifr_pkg::ST_TOO_LONG, '0, ifr_pkg::RPL_NONE, 1'b0, 1'b0);
      return;
    end
    raw_cnt++;
    if (b == ifr_pkg::FLAG_BYTE) begin
      ph  = ifr_pkg::PH_HUNT;
      seq = (ctrl_q == ifr_pkg::CTRL_I1);
      if (raw_cnt < 5) begin
        post_verdict(ifr_pkg::ST_TOO_SHORT, '0, ifr_pkg::RPL_NONE, 1'b0, 1'b0);
      end else if (bcc1_q != (addr_q ^ ctrl_q)) begin
        post_verdict(ifr_pkg::ST_BCC1, '0, ifr_pkg::RPL_NONE, 1'b0, seq);
      end else if (ctrl_q != ifr_pkg::CTRL_I0 && ctrl_q != ifr_pkg::CTRL_I1) begin
        post_verdict(ifr_pkg::ST_NOT_I, '0, ifr_pkg::RPL_NONE, 1'b0, seq);
      end else begin
        if (raw_cnt == 5)        st = ifr_pkg::ST_EMPTY;
        else if (ovf_q)          st = ifr_pkg::ST_OVERFLOW;
        else if (esc_q)          st = ifr_pkg::ST_ESCAPE;
        else if (body_cnt == 0)  st = ifr_pkg::ST_EMPTY;
        else if (xor_q != 8'h00) st = ifr_pkg::ST_BCC2;
        else                     st = ifr_pkg::ST_ACCEPTED;
        if (st != ifr_pkg::ST_ACCEPTED) begin
          post_verdict(st, '0, ifr_pkg::RPL_REJ, exp_seq, seq);
        end else if (seq == exp_seq) begin
          exp_seq = ~exp_seq;
          post_verdict(ifr_pkg::ST_ACCEPTED, 9'(body_cnt - 1), ifr_pkg::RPL_RR,
                       exp_seq, seq);
        end else begin
          post_verdict(ifr_pkg::ST_DUPLICATE, '0, ifr_pkg::RPL_RR, exp_seq, seq);
        end
      end
      return;
    end
    if (ph == ifr_pkg::PH_HDR) begin
      case (raw_cnt)
        2: addr_q = b;
        3: ctrl_q = b;
        default: begin
          bcc1_q = b;
          ph     = ifr_pkg::PH_BODY;
        end
      endcase
      return;
    end
    // body: unstuff
    if (esc_q) begin
      esc_q = 1'b0;
      v     = b ^ ifr_pkg::ESC_MASK;
    end else if (b == ifr_pkg::ESC_BYTE) begin
      esc_q = 1'b1;
      return;
    end else begin
      v = b;
    end
    if (ovf_q) return;
    if (body_cnt >= MaxPayload + 1) begin
      ovf_q = 1'b1;
      return;
    end
    // the previous body byte leaves now; the last one (BCC2) never does
    if (body_cnt > 0) begin
      r      = '0;
      r.data = held_q;
      due_q.push_back(r);
    end
    held_q = v;
    body_cnt++;
    xor_q = xor_q ^ v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] v, input bit drained);
    line_byte_t lb;
    lb.value        = v;
    lb.wait_drained = drained;
    line_q.push_back(lb);
  endfunction

  function automatic logic [7:0] any_but_flag();
    logic [7:0] v;
    do v = 8'($urandom); while (v == ifr_pkg::FLAG_BYTE);
    return v;
  endfunction

  // Payload values leaning towards the ones that need stuffing.
  function automatic logic [7:0] body_pick();
    case ($urandom_range(0, 11))
      0:       return ifr_pkg::FLAG_BYTE;
      1:       return ifr_pkg::ESC_BYTE;
      2:       return ifr_pkg::FLAG_BYTE ^ ifr_pkg::ESC_MASK;
      3:       return ifr_pkg::ESC_BYTE ^ ifr_pkg::ESC_MASK;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Stuffs one body value; now and then escapes a value that needs none,
  // unless the escaped form would read as a flag.
  function automatic void queue_body(input logic [7:0] v);
    if (v == ifr_pkg::FLAG_BYTE || v == ifr_pkg::ESC_BYTE ||
        ((v ^ ifr_pkg::ESC_MASK) != ifr_pkg::FLAG_BYTE && $urandom_range(0, 15) == 0)) begin
      queue_byte(ifr_pkg::ESC_BYTE, 1'b0);
      queue_byte(v ^ ifr_pkg::ESC_MASK, 1'b0);
    end else begin
      queue_byte(v, 1'b0);
    end
  endfunction

  // Whole frame: opener(s), header, stuffed payload and BCC2, closer.
  function automatic void queue_frame(input logic [7:0] addr, ctrl, hcheck,
                                      input int plen, input bit spoil_bcc2,
                                      input bit dangle, input bit drained);
    logic [7:0] v;
    logic [7:0] sum;
    int         i;
    queue_byte(ifr_pkg::FLAG_BYTE, drained);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(addr, 1'b0);
    queue_byte(ctrl, 1'b0);
    queue_byte(hcheck, 1'b0);
    sum = 8'h00;
    for (i = 0; i < plen; i++) begin
      v   = body_pick();
      sum = sum ^ v;
      queue_body(v);
    end
    if (spoil_bcc2) sum = sum ^ 8'($urandom_range(1, 255));
    queue_body(sum);
    if (dangle) queue_byte(ifr_pkg::ESC_BYTE, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
  endfunction

  function automatic bit take_break();
    if (cycle_cnt >= CalmFrom && cycle_cnt < CalmTo) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Line driver: one item offered at a time, held while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : line_driver
    bit offer;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rx_line_step(rx_byte_i);
        line_q.delete(0);
        bytes_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        offer = line_q.size() != 0 && !take_break();
        // a marked item waits until the block has given everything back
        if (offer && line_q[0].wait_drained && due_q.size() != 0) offer = 1'b0;
        in_valid_i <= offer;
        if (offer) rx_byte_i <= line_q[0].value;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and stall generation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    rx_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item expected none actual status %0h data %0h",
                   $time, status_o, data_byte_o);
        end else begin
          want = due_q.pop_front();
          check_field("is_status", want.is_st, is_status_o);
          check_field("data_byte", want.data, data_byte_o);
          check_field("status", want.st, status_o);
          check_field("payload_length", want.len, payload_length_o);
          check_field("reply_kind", want.reply, reply_kind_o);
          check_field("reply_bit", want.rbit, reply_bit_o);
          check_field("frame_seq", want.fseq, frame_seq_o);
        end
        if (is_status_o) verdict_cnt[status_o]++;
        else payload_seen++;
      end
      // one long hold-off so the skid fills and the line side backs up
      if (holdoff_left != 0) begin
        holdoff_left--;
      end else if (!holdoff_done && bytes_sent >= HoldoffAt) begin
        holdoff_left = HoldoffLen;
        holdoff_done = 1'b1;
      end
      out_stall_i <= (holdoff_left != 0) || take_break();
    end
  end

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timed out after %0d cycles, %0d line bytes and %0d results pending",
               cycle_cnt, line_q.size(), due_q.size());
      $display("[info_frame_receiver] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed frames, then random frames, noise and broken runs.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] bad;
    int         frame_no;
    int         plen;
    int         pick;
    int         floor_len;
    bit         drained;

    // noise while hunting, byte extremes
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // repeated opener, escape of an escape, accepted with bit 0
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ifr_pkg::CTRL_I0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ifr_pkg::ESC_BYTE, 1'b0);
    queue_byte(ifr_pkg::ESC_BYTE, 1'b0);
    queue_byte(ifr_pkg::ESC_BYTE ^ ifr_pkg::ESC_MASK, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    // too short; the closer does not open the next frame
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    // header only: empty body
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(ifr_pkg::CTRL_I1, 1'b0);
    queue_byte(8'h01 ^ ifr_pkg::CTRL_I1, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    // escape left dangling before the closer
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(ifr_pkg::CTRL_I0, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(ifr_pkg::ESC_BYTE, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    // same bit again: duplicate
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(ifr_pkg::CTRL_I0, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
    // header check wrong, control byte of no I-frame, body check spoilt
    queue_frame(8'h05, ifr_pkg::CTRL_I1, 8'h05 ^ ifr_pkg::CTRL_I1 ^ 8'h10, 2,
                1'b0, 1'b0, 1'b0);
    queue_frame(8'h05, 8'h11, 8'h05 ^ 8'h11, 2, 1'b0, 1'b0, 1'b0);
    queue_frame(8'h05, ifr_pkg::CTRL_I1, 8'h05 ^ ifr_pkg::CTRL_I1, 3, 1'b1, 1'b0, 1'b0);

    floor_len = TargetBytes;
    frame_no  = 0;
    while (line_q.size() < floor_len || frame_no <= 9) begin
      drained = (frame_no == 0 || frame_no == 5);
      addr    = any_but_flag();
      ctrl    = $urandom_range(0, 1) ? ifr_pkg::CTRL_I1 : ifr_pkg::CTRL_I0;
      plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      if (frame_no == 3) begin
        // largest payload that still gets through
        queue_frame(addr, ctrl, addr ^ ctrl, MaxPayload, 1'b0, 1'b0, drained);
      end else if (frame_no == 6) begin
        // one byte too many: overflow
        queue_frame(addr, ctrl, addr ^ ctrl, MaxPayload + 1, 1'b0, 1'b0, drained);
      end else if (frame_no == 9) begin
        // runs past the frame length cap
        queue_frame(addr, ctrl, addr ^ ctrl, MaxFrame - 3, 1'b0, 1'b0, drained);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          queue_frame(addr, ctrl, addr ^ ctrl, plen, 1'b0, 1'b0, drained);
        end else if (pick < 65) begin
          queue_frame(addr, ctrl, addr ^ ctrl ^ 8'($urandom_range(1, 255)), plen,
                      1'b0, 1'b0, drained);
        end else if (pick < 70) begin
          do bad = any_but_flag();
          while (bad == ifr_pkg::CTRL_I0 || bad == ifr_pkg::CTRL_I1);
          queue_frame(addr, bad, addr ^ bad, plen, 1'b0, 1'b0, drained);
        end else if (pick < 75) begin
          queue_frame(addr, ctrl, addr ^ ctrl, plen, 1'b1, 1'b0, drained);
        end else if (pick < 79) begin
          queue_frame(addr, ctrl, addr ^ ctrl, plen, 1'b0, 1'b1, drained);
        end else if (pick < 83) begin
          queue_byte(ifr_pkg::FLAG_BYTE, drained);
          repeat ($urandom_range(1, 2)) queue_byte(any_but_flag(), 1'b0);
          queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
        end else if (pick < 87) begin
          queue_byte(ifr_pkg::FLAG_BYTE, drained);
          queue_byte(addr, 1'b0);
          queue_byte(ctrl, 1'b0);
          queue_byte(addr ^ ctrl, 1'b0);
          queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
        end else if (pick < 93) begin
          // line noise between frames
          queue_byte(any_but_flag(), drained);
          repeat ($urandom_range(0, 5)) queue_byte(any_but_flag(), 1'b0);
        end else begin
          // flag-rich garbage; a double flag afterwards resyncs in any phase
          queue_byte(8'($urandom), drained);
          repeat ($urandom_range(2, 7))
            queue_byte($urandom_range(0, 2) == 0 ? ifr_pkg::FLAG_BYTE : 8'($urandom),
                       1'b0);
          queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
          queue_byte(ifr_pkg::FLAG_BYTE, 1'b0);
        end
      end
      frame_no++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (line_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("line bytes %0d, result items %0d (payload %0d), frames judged %0d",
             bytes_sent, results_seen, payload_seen, results_seen - payload_seen);
    $display("accepted %0d, duplicate %0d, body faults %0d, header or length faults %0d",
             verdict_cnt[ifr_pkg::ST_ACCEPTED], verdict_cnt[ifr_pkg::ST_DUPLICATE],
             verdict_cnt[ifr_pkg::ST_EMPTY] + verdict_cnt[ifr_pkg::ST_ESCAPE]
               + verdict_cnt[ifr_pkg::ST_OVERFLOW] + verdict_cnt[ifr_pkg::ST_BCC2],
             verdict_cnt[ifr_pkg::ST_TOO_LONG] + verdict_cnt[ifr_pkg::ST_TOO_SHORT]
               + verdict_cnt[ifr_pkg::ST_BCC1] + verdict_cnt[ifr_pkg::ST_NOT_I]);
    if (mismatches == 0) begin
      $display("[info_frame_receiver] OK");
    end else begin
      $display("[info_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
